[hw/rtl/rfp_pkg.sv]
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared types and constants of the route frame parser and responder.
// ----------------------------------------------------------------------------
`default_nettype none

package rfp_pkg;

  localparam int FRAME_LEN    = 13;
  localparam int STORE_LEN    = FRAME_LEN - 1;  // the end byte is never kept
  localparam int CNT_W        = $clog2(FRAME_LEN);

  localparam logic [7:0] START_MARK = 8'h7F;
  localparam logic [7:0] END_MARK   = 8'h7E;
  localparam logic [7:0] DISP_HEAD  = 8'h7D;
  localparam logic [7:0] DISP_TAIL  = 8'h7C;
  localparam logic [7:0] SHAPE_HEAD = 8'h7B;
  localparam logic [7:0] SHAPE_TAIL = 8'h7A;

  // frame byte positions
  localparam int POS_X_AT  = 1;
  localparam int POS_Y_AT  = 3;
  localparam int GOAL_X_AT = 5;
  localparam int GOAL_Y_AT = 7;
  localparam int ANGLE_AT  = 9;
  localparam int SHAPE_AT  = 11;

  // round(pi/180 * 2^40), split so each product stays narrow
  localparam logic [34:0] DEG2RAD_Q40 = 35'd19190098069;
  localparam int          SPLIT       = 18;
  localparam logic [16:0] DEG2RAD_HI  = DEG2RAD_Q40[34:SPLIT];
  localparam logic [17:0] DEG2RAD_LO  = DEG2RAD_Q40[SPLIT-1:0];
  localparam int          PHI_W       = 33;
  localparam int          PLO_W       = 34;
  localparam int          SUM_W       = 51;
  localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << 23;
  localparam int          ANGLE_W     = 27;

  localparam int NUM_SHAPE  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DISP_LEN  = 8;
  localparam int REPLY_MAX = DISP_LEN + 2 + 2 * NUM_SHAPE;
  localparam int IDX_W     = $clog2(REPLY_MAX);

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic [15:0]        goal_x;
    logic [15:0]        goal_y;
    logic [ANGLE_W-1:0] angle;
  } route_t;

  typedef struct packed {
    route_t      route;
    logic [15:0] disp_x;
    logic [15:0] disp_y;
    logic [15:0] heading;
    logic        shape;
  } job_t;

  typedef logic [15:0] shape_regs_t [NUM_SHAPE];

endpackage

`default_nettype wire

[hw/rtl/rfp_if.sv]
// ----------------------------------------------------------------------------
// rfp_if
// Valid/ready channels of the route frame parser: received items and replies.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfp_in_if
  import rfp_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [7:0]         rx_byte;
  logic signed [15:0] disp_x;
  logic signed [15:0] disp_y;
  logic [15:0]        heading_deg;

  modport source (output valid, mode, rx_byte, disp_x, disp_y, heading_deg,
                  input ready);
  modport sink   (input valid, mode, rx_byte, disp_x, disp_y, heading_deg,
                  output ready);
endinterface

interface rfp_out_if
  import rfp_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [7:0]         tx_byte;
  logic               last_of_run;
  logic [15:0]        pos_x;
  logic [15:0]        pos_y;
  logic [15:0]        goal_x;
  logic [15:0]        goal_y;
  logic [ANGLE_W-1:0] angle_rad_q16;

  modport source (output valid, tx_byte, last_of_run, pos_x, pos_y, goal_x, goal_y,
                  angle_rad_q16, input ready);
  modport sink   (input valid, tx_byte, last_of_run, pos_x, pos_y, goal_x, goal_y,
                  angle_rad_q16, output ready);
endinterface

`default_nettype wire

[hw/rtl/rfp_front.sv]
// ----------------------------------------------------------------------------
// rfp_front
// Frame assembly, validation, route latch capture and angle conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module rfp_front
  import rfp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rfp_in_if.sink    rx,
  output logic      job_valid_o,
  output job_t      job_o,
  input  wire logic job_ready_i
);

  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       store_q [STORE_LEN];
  logic             pending_q, pending_d;
  logic             s1_valid_q, s1_valid_d;
  job_t             s1_job_q;
  logic [PHI_W-1:0] p_hi_q;
  logic [PLO_W-1:0] p_lo_q;
  logic [15:0]      angle_deg;
  logic [SUM_W-1:0] angle_sum;
  logic             accept, byte_accept, arm, frame_done, s1_move;
  job_t             new_job;

  assign s1_move     = s1_valid_q && job_ready_i;
  assign rx.ready    = !s1_valid_q || job_ready_i;
  assign accept      = rx.valid && rx.ready;
  assign byte_accept = accept && !rx.mode;
  assign arm         = accept && rx.mode;
  assign frame_done  = byte_accept && (count_q == CNT_W'(STORE_LEN)) &&
                       (rx.rx_byte == END_MARK);
  assign angle_deg   = {store_q[ANGLE_AT], store_q[ANGLE_AT+1]};

  always_comb begin
    count_d = count_q;
    if (byte_accept) begin
      if (count_q == '0) begin
        count_d = (rx.rx_byte == START_MARK) ? CNT_W'(1) : '0;
      end else if (count_q == CNT_W'(STORE_LEN)) begin
        count_d = '0;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  always_comb begin
    pending_d = pending_q;
    if (arm) begin
      pending_d = 1'b1;
    end else if (frame_done && store_q[SHAPE_AT] != 8'h00) begin
      pending_d = 1'b0;
    end
  end

  always_comb begin
    new_job              = '0;
    new_job.route.pos_x  = {store_q[POS_X_AT], store_q[POS_X_AT+1]};
    new_job.route.pos_y  = {store_q[POS_Y_AT], store_q[POS_Y_AT+1]};
    new_job.route.goal_x = {store_q[GOAL_X_AT], store_q[GOAL_X_AT+1]};
    new_job.route.goal_y = {store_q[GOAL_Y_AT], store_q[GOAL_Y_AT+1]};
    new_job.disp_x       = rx.disp_x;
    new_job.disp_y       = rx.disp_y;
    new_job.heading      = rx.heading_deg;
    new_job.shape        = pending_q && (store_q[SHAPE_AT] == 8'h00);
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (frame_done) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      pending_q  <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      pending_q  <= pending_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < STORE_LEN; i++) begin
      if (byte_accept && count_q == CNT_W'(i)) begin
        store_q[i] <= rx.rx_byte;
      end
    end
    if (frame_done) begin
      s1_job_q <= new_job;
      p_hi_q   <= PHI_W'(angle_deg * DEG2RAD_HI);
      p_lo_q   <= PLO_W'(angle_deg * DEG2RAD_LO);
    end
  end

  // degrees to radians in Q16, rounded to nearest
  assign angle_sum = {p_hi_q, SPLIT'(0)} + SUM_W'(p_lo_q) + ROUND_HALF;

  always_comb begin
    job_o             = s1_job_q;
    job_o.route.angle = angle_sum[SUM_W-1:SUM_W-ANGLE_W];
  end

  assign job_valid_o = s1_valid_q;

endmodule

`default_nettype wire

[hw/rtl/rfp_queue.sv]
// ----------------------------------------------------------------------------
// rfp_queue
// Short job queue between the frame parser and the reply sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module rfp_queue
  import rfp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire job_t push_data_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output job_t      pop_data_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  job_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_QW-1:0] fill_q, fill_d;
  logic              push, pop;

  assign push_ready_o = (fill_q != CNT_QW'(QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + CNT_QW'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rfp_back.sv]
// ----------------------------------------------------------------------------
// rfp_back
// Reply sequencer: sends the displacement reply and an optional shape frame.
// ----------------------------------------------------------------------------
`default_nettype none

module rfp_back
  import rfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        job_valid_i,
  output logic             job_ready_o,
  input  wire job_t        job_i,
  input  wire shape_regs_t shape_i,
  rfp_out_if.source        tx
);

  logic             job_valid_q, job_valid_d;
  job_t             job_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q;
  logic             out_last_q;
  route_t           out_route_q;
  logic [7:0]       msg [REPLY_MAX];
  logic             load, emit, is_last, pop;

  always_comb begin
    msg[0] = DISP_HEAD;
    msg[1] = job_q.disp_x[15:8];
    msg[2] = job_q.disp_x[7:0];
    msg[3] = job_q.disp_y[15:8];
    msg[4] = job_q.disp_y[7:0];
    msg[5] = job_q.heading[15:8];
    msg[6] = job_q.heading[7:0];
    msg[DISP_LEN-1] = DISP_TAIL;
    msg[DISP_LEN]   = SHAPE_HEAD;
    for (int i = 0; i < NUM_SHAPE; i++) begin
      msg[DISP_LEN+1+2*i] = shape_i[i][15:8];
      msg[DISP_LEN+2+2*i] = shape_i[i][7:0];
    end
    msg[REPLY_MAX-1] = SHAPE_TAIL;
  end

  assign is_last = job_q.shape ? (idx_q == IDX_W'(REPLY_MAX - 1))
                               : (idx_q == IDX_W'(DISP_LEN - 1));
  assign load    = !out_valid_q || tx.ready;
  assign emit    = load && job_valid_q;
  assign pop     = !job_valid_q || (emit && is_last);
  assign job_ready_o = pop;

  always_comb begin
    job_valid_d = job_valid_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (pop) begin
      job_valid_d = job_valid_i;
      idx_d       = '0;
    end else if (emit) begin
      idx_d = idx_q + IDX_W'(1);
    end
    if (load) begin
      out_valid_d = job_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && job_valid_i) begin
      job_q <= job_i;
    end
    if (emit) begin
      out_byte_q  <= msg[idx_q];
      out_last_q  <= is_last;
      out_route_q <= job_q.route;
    end
  end

  assign tx.valid         = out_valid_q;
  assign tx.tx_byte       = out_byte_q;
  assign tx.last_of_run   = out_last_q;
  assign tx.pos_x         = out_route_q.pos_x;
  assign tx.pos_y         = out_route_q.pos_y;
  assign tx.goal_x        = out_route_q.goal_x;
  assign tx.goal_y        = out_route_q.goal_y;
  assign tx.angle_rad_q16 = out_route_q.angle;

endmodule

`default_nettype wire

[hw/rtl/route_frame_parser_responder.sv]
// ----------------------------------------------------------------------------
// route_frame_parser_responder
// Parses 13-byte route frames and answers with displacement and shape replies.
// ----------------------------------------------------------------------------
// The parser takes one item per cycle while its job register is free or the
// queue takes its job. Each valid frame (0x7F ... 0x7E) becomes a job that is
// registered in the parser and then enters a two-deep queue; the reply
// sequencer takes it into its job register and offers reply bytes from a
// registered output stage, one reply byte per cycle while the receiver is
// ready: 8 bytes for a displacement reply, 22 when a shape frame follows. A
// frame is 13 input bytes, so frames followed by a shape frame can be held
// back by the reply sequencer through the queue; bytes that complete no frame
// and shape arm items take no room in the queue. Route fields and the angle
// travel with every reply byte as they stood after the frame that caused it.
// Shape registers are read when the shape frame is sent.
`default_nettype none

module route_frame_parser_responder
  import rfp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  rfp_in_if.sink                     rx_i,
  rfp_out_if.source                  tx_o
);

  shape_regs_t shape_q;
  logic        f_valid, f_ready, b_valid, b_ready;
  job_t        f_job, b_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SHAPE; i++) begin
        shape_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_SHAPE; i++) begin
        if (cfg_we_i && cfg_idx_i == CFG_IDX_W'(i)) begin
          shape_q[i] <= cfg_data_i;
        end
      end
    end
  end

  rfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx          (rx_i),
    .job_valid_o (f_valid),
    .job_o       (f_job),
    .job_ready_i (f_ready)
  );

  rfp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_job),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_job)
  );

  rfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (b_valid),
    .job_ready_o (b_ready),
    .job_i       (b_job),
    .shape_i     (shape_q),
    .tx          (tx_o)
  );

endmodule

`default_nettype wire

[hw/rtl/rfp_checker.sv]
// ----------------------------------------------------------------------------
// rfp_checker
// Port-level checks of the reply channel of the route frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

module rfp_checker
  import rfp_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic [7:0]         tx_byte_i,
  input wire logic               last_of_run_i,
  input wire logic [15:0]        pos_x_i,
  input wire logic [15:0]        goal_y_i,
  input wire logic [ANGLE_W-1:0] angle_i
);

  // stalled reply stays
  a_valid_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("reply valid dropped while stalled");

  a_byte_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(tx_byte_i) && $stable(last_of_run_i))
    else $error("reply byte changed while stalled");

  // every run closes with a tail marker
  a_tail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && last_of_run_i |-> tx_byte_i == DISP_TAIL ||
                                                    tx_byte_i == SHAPE_TAIL)
    else $error("run ended on a byte that is no tail marker");

  // route fields pos_x and goal_y and the angle are constant within one run
  a_route_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_of_run_i |=>
      !out_valid_i || (pos_x_i == $past(pos_x_i) && goal_y_i == $past(goal_y_i) &&
                       angle_i == $past(angle_i)))
    else $error("route fields changed inside a run");

endmodule

bind route_frame_parser_responder rfp_checker u_rfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (tx_o.valid),
  .out_ready_i   (tx_o.ready),
  .tx_byte_i     (tx_o.tx_byte),
  .last_of_run_i (tx_o.last_of_run),
  .pos_x_i       (tx_o.pos_x),
  .goal_y_i      (tx_o.goal_y),
  .angle_i       (tx_o.angle_rad_q16)
);

`default_nettype wire
